// ===== src/psd_pkg.sv =====
`timescale 1ns / 1ps
package psd_pkg;

  localparam int PSD_COORD_BITS = 24;

  // Nearest-point codes
  localparam logic [1:0] CASE_START = 2'd0;
  localparam logic [1:0] CASE_END   = 2'd1;
  localparam logic [1:0] CASE_FOOT  = 2'd2;

  // Control that travels with each word down the pipe
  typedef struct packed {
    logic       valid;
    logic [1:0] nearest_case;
  } psd_ctl_t;

endpackage

// ===== src/psd_in_if.sv =====
`timescale 1ns / 1ps
interface psd_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                output ready);
endinterface

// ===== src/psd_out_if.sv =====
`timescale 1ns / 1ps
interface psd_out_if #(parameter int COORD_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   distance;
  logic [1:0]            nearest_case;

  modport source (output valid, distance, nearest_case, input ready);
  modport sink (input valid, distance, nearest_case, output ready);
endinterface

// ===== src/psd_front.sv =====
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; #(
  parameter int COORD_BITS = PSD_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by,
  output psd_ctl_t                      ctl,
  output logic [4*COORD_BITS+5:0]       num,
  output logic [4*COORD_BITS+5:0]       den
);
  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int SW = 2 * C + 3;
  localparam int WW = 4 * C + 6;

  // stage 1: differences
  logic signed [DW-1:0] dx, dy, ux, uy, vx, vy;
  logic                 v1;
  // stage 2: products
  logic signed [PW-1:0] dxux, dyuy, dxvx, dyvy, dxuy, dyux;
  logic signed [PW-1:0] uxux, uyuy, vxvx, vyvy, dxdx, dydy;
  logic                 v2;
  // stage 3: sums and case
  logic [PW-1:0]        mag, dist2, len2;
  psd_ctl_t             c3;
  // stage 4: partial squares of the cross product
  logic [PW-1:0]        p_hh, p_hl, p_ll, dist2_4, len2_4;
  psd_ctl_t             c4;

  logic signed [SW-1:0] dot_a, dot_b, cross_ab;
  logic [SW-1:0]        cross_abs;
  logic [1:0]           case_sel;

  // Decide case from the two dot products
  always_comb begin
    dot_a = SW'(dxux) + SW'(dyuy);
    dot_b = SW'(dxvx) + SW'(dyvy);
    cross_ab = SW'(dxuy) - SW'(dyux);
    cross_abs = cross_ab[SW-1] ? SW'(-cross_ab) : SW'(cross_ab);
    if (!dot_a[SW-1]) begin
      case_sel = CASE_START;
    end else if (dot_b[SW-1] || dot_b == '0) begin
      case_sel = CASE_END;
    end else begin
      case_sel = CASE_FOOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      c3 <= '0;
      c4 <= '0;
      ctl <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      c3 <= '{valid: v2, nearest_case: case_sel};
      c4 <= c3;
      ctl <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DW'(ax) - DW'(bx);
      dy <= DW'(ay) - DW'(by);
      ux <= DW'(px) - DW'(ax);
      uy <= DW'(py) - DW'(ay);
      vx <= DW'(px) - DW'(bx);
      vy <= DW'(py) - DW'(by);
      dxux <= dx * ux;
      dyuy <= dy * uy;
      dxvx <= dx * vx;
      dyvy <= dy * vy;
      dxuy <= dx * uy;
      dyux <= dy * ux;
      uxux <= ux * ux;
      uyuy <= uy * uy;
      vxvx <= vx * vx;
      vyvy <= vy * vy;
      dxdx <= dx * dx;
      dydy <= dy * dy;
      // cross magnitude, squared distance to the chosen endpoint and squared length
      mag  <= PW'(cross_abs);
      dist2 <= (case_sel == CASE_START) ? PW'(uxux + uyuy) : PW'(vxvx + vyvy);
      len2 <= PW'(dxdx + dydy);
      // split the cross magnitude into halves before squaring
      p_hh <= PW'(mag[PW-1:DW]) * PW'(mag[PW-1:DW]);
      p_hl <= PW'(mag[PW-1:DW]) * PW'(mag[DW-1:0]);
      p_ll <= PW'(mag[DW-1:0]) * PW'(mag[DW-1:0]);
      dist2_4 <= dist2;
      len2_4 <= len2;
      if (c4.nearest_case == CASE_FOOT) begin
        num <= (WW'(p_hh) << (2 * DW)) + (WW'(p_hl) << (DW + 1)) + WW'(p_ll);
        den <= WW'(len2_4);
      end else begin
        num <= WW'(dist2_4);
        den <= WW'(1);
      end
    end
  end
endmodule

// ===== src/psd_cell.sv =====
`timescale 1ns / 1ps
module psd_cell import psd_pkg::*; #(
  parameter int COORD_BITS = PSD_COORD_BITS,
  parameter int BIT = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  psd_ctl_t                  ctl_in,
  input  logic [4*COORD_BITS+5:0]   r_in,
  input  logic [4*COORD_BITS+5:0]   t_in,
  input  logic [4*COORD_BITS+5:0]   den_in,
  input  logic [COORD_BITS+1:0]     n_in,
  output psd_ctl_t                  ctl_out,
  output logic [4*COORD_BITS+5:0]   r_out,
  output logic [4*COORD_BITS+5:0]   t_out,
  output logic [4*COORD_BITS+5:0]   den_out,
  output logic [COORD_BITS+1:0]     n_out
);
  localparam int WW = 4 * COORD_BITS + 6;
  localparam int RW = COORD_BITS + 2;

  logic [WW-1:0] delta;
  logic          take;

  // Try this root bit: residual must cover the growth of n*n*den
  always_comb begin
    delta = (t_in << (BIT + 1)) + (den_in << (2 * BIT));
    take  = (delta <= r_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      r_out <= take ? r_in - delta : r_in;
      t_out <= take ? t_in + (den_in << BIT) : t_in;
      n_out <= n_in | (RW'(take) << BIT);
    end
  end
endmodule

// ===== src/point_segment_distance.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Words
// in       in   point_x/y, start_x/y, end_x/y (signed COORD_BITS each)
// out      out  distance (COORD_BITS+1), nearest_case (2)
//
// One word per cycle while out is not stalled; the pipe is 5 front stages plus COORD_BITS+2 root cells.
// The root chain has one cell per root bit and follows the front stages.
// Synchronous reset clears the control words (valid and nearest_case) only.
// The whole pipe holds while out is stalled with a word waiting.
module point_segment_distance import psd_pkg::*; #(
  parameter int COORD_BITS = PSD_COORD_BITS
) (
  input  logic    clk,
  input  logic    rst,
  psd_in_if.sink  in,
  psd_out_if.source out
);
  localparam int WW = 4 * COORD_BITS + 6;
  localparam int RW = COORD_BITS + 2;

  logic en;
  psd_ctl_t            ctl [RW+1];
  logic [WW-1:0]       r   [RW+1];
  logic [WW-1:0]       t   [RW+1];
  logic [WW-1:0]       den [RW+1];
  logic [RW-1:0]       n   [RW+1];

  // Advance unless a finished word is blocked
  assign en = !ctl[RW].valid || out.ready;
  assign in.ready = en;

  psd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in.valid),
    .px(in.point_x), .py(in.point_y), .ax(in.start_x), .ay(in.start_y),
    .bx(in.end_x), .by(in.end_y),
    .ctl(ctl[0]), .num(r[0]), .den(den[0])
  );
  assign t[0] = '0;
  assign n[0] = '0;

  // Root chain, most significant bit first
  for (genvar i = 0; i < RW; i++) begin : g_cell
    psd_cell #(.COORD_BITS(COORD_BITS), .BIT(RW - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl[i]), .r_in(r[i]), .t_in(t[i]), .den_in(den[i]), .n_in(n[i]),
      .ctl_out(ctl[i+1]), .r_out(r[i+1]), .t_out(t[i+1]), .den_out(den[i+1]),
      .n_out(n[i+1])
    );
  end

  assign out.valid = ctl[RW].valid;
  assign out.nearest_case = ctl[RW].nearest_case;
  assign out.distance = n[RW][COORD_BITS:0];

`ifndef SYNTHESIS
  a_case_code: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.nearest_case != 2'd3)
    else $error("unused nearest_case code");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in.ready == (!out.valid || out.ready))
    else $error("ready does not follow output stall");
  a_reset: assert property (@(posedge clk) rst |=> !out.valid)
    else $error("output valid after reset");
`endif
endmodule

// ===== verif/point_segment_distance_tb.sv =====
`timescale 1ns / 1ps
module point_segment_distance_tb;
  import psd_pkg::*;

  localparam int CB       = PSD_COORD_BITS;
  localparam int ROOT_W   = CB + 2;
  localparam int WDOG_MAX = 5000;
  localparam int N_RANDOM = 1100;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [127:0]  big_t;

  typedef struct packed {
    coord_t px, py, ax, ay, bx, by;
  } query_t;

  typedef struct packed {
    logic [CB:0] distance;
    logic [1:0]  nearest_case;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  psd_in_if  #(.COORD_BITS(CB)) in_ch ();
  psd_out_if #(.COORD_BITS(CB)) out_ch ();

  point_segment_distance #(.COORD_BITS(CB)) dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  query_t  pending_q[$];
  answer_t answer_q[$];
  int      fails = 0;
  int      checked = 0;
  int      case_hits[3] = '{0, 0, 0};
  bit      quiet = 1'b0;

  // Largest n with n*n*den <= num
  function automatic logic [ROOT_W-1:0] floor_root(big_t num, big_t den);
    logic [ROOT_W-1:0] n;
    logic [ROOT_W-1:0] cand;
    big_t              c;
    n = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      cand = n | (ROOT_W'(1) << b);
      c = big_t'(cand);
      if (c * c * den <= num) n = cand;
    end
    return n;
  endfunction

  function automatic answer_t seg_distance(query_t q);
    big_t    dx, dy, ux, uy, vx, vy, dot_a, dot_b, cr, len2;
    answer_t r;
    dx = big_t'(q.ax) - big_t'(q.bx);
    dy = big_t'(q.ay) - big_t'(q.by);
    ux = big_t'(q.px) - big_t'(q.ax);
    uy = big_t'(q.py) - big_t'(q.ay);
    vx = big_t'(q.px) - big_t'(q.bx);
    vy = big_t'(q.py) - big_t'(q.by);
    dot_a = dx * ux + dy * uy;
    dot_b = dx * vx + dy * vy;
    if (dot_a >= 0) begin
      r.distance     = (CB+1)'(floor_root(ux * ux + uy * uy, 1));
      r.nearest_case = CASE_START;
    end else if (dot_b <= 0) begin
      r.distance     = (CB+1)'(floor_root(vx * vx + vy * vy, 1));
      r.nearest_case = CASE_END;
    end else begin
      cr = dx * uy - dy * ux;
      if (cr < 0) cr = -cr;
      len2 = dx * dx + dy * dy;
      r.distance     = (CB+1)'(floor_root(cr * cr, len2));
      r.nearest_case = CASE_FOOT;
    end
    return r;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  // Offset from a base, kept inside the coordinate range
  function automatic coord_t near_coord(int base, int spread);
    int v;
    v = base + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return coord_t'(v);
  endfunction

  function automatic query_t mk(int px, int py, int ax, int ay, int bx, int by);
    query_t q;
    q.px = coord_t'(px); q.py = coord_t'(py);
    q.ax = coord_t'(ax); q.ay = coord_t'(ay);
    q.bx = coord_t'(bx); q.by = coord_t'(by);
    return q;
  endfunction

  // Fill the word queue: directed corners first, then random geometry
  initial begin
    query_t q;
    int     bx0, by0, sp, kind;

    pending_q.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(8388607, 8388607, -8388608, -8388608, -8388608, -8388608));
    pending_q.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607));
    pending_q.push_back(mk(8388607, -8388608, -8388608, 8388607, 8388607, -8388608));
    pending_q.push_back(mk(-8388608, 8388607, -8388608, -8388608, 8388607, 8388607));
    pending_q.push_back(mk(8388607, -8388608, -8388608, -8388608, 8388607, 8388607));
    pending_q.push_back(mk(-8388608, 8388607, 8388607, -8388608, -8388608, 8388607));
    pending_q.push_back(mk(0, 8388607, -8388608, 0, 8388607, 0));
    pending_q.push_back(mk(0, -8388608, -8388608, 0, 8388607, 0));
    // degenerate segment
    pending_q.push_back(mk(1000, -2000, 300, 300, 300, 300));
    // tie with the start point
    pending_q.push_back(mk(0, 500, 0, 0, 256, 0));
    // tie with the end point
    pending_q.push_back(mk(256, 77, 0, 0, 256, 0));
    // beyond each end, and interior
    pending_q.push_back(mk(-50, 40, 0, 0, 256, 0));
    pending_q.push_back(mk(400, -40, 0, 0, 256, 0));
    pending_q.push_back(mk(100, 300, 0, 0, 256, 0));
    pending_q.push_back(mk(100, -300, 0, 0, 256, 0));
    pending_q.push_back(mk(7, 3, -1, -1, 1, 1));
    pending_q.push_back(mk(-1, -1, -1, -1, 0, 0));
    pending_q.push_back(mk(128, 128, 0, 0, 256, 256));
    pending_q.push_back(mk(8388607, 8388607, 0, 0, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        q.px = any_coord(); q.py = any_coord();
        q.ax = any_coord(); q.ay = any_coord();
        q.bx = any_coord(); q.by = any_coord();
      end else begin
        bx0 = $signed($urandom_range(0, 16777215)) - 8388608;
        by0 = $signed($urandom_range(0, 16777215)) - 8388608;
        sp  = (kind < 6) ? 2000 : 200000;
        q.ax = near_coord(bx0, sp); q.ay = near_coord(by0, sp);
        q.bx = near_coord(bx0, sp); q.by = near_coord(by0, sp);
        q.px = near_coord(bx0, 2 * sp); q.py = near_coord(by0, 2 * sp);
        if (kind == 9) begin
          q.bx = q.ax; q.by = q.ay;
        end
      end
      pending_q.push_back(q);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && answer_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("checked %0d results: %0d at start, %0d at end, %0d at interior foot",
             checked, case_hits[0], case_hits[1], case_hits[2]);
    if (fails == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Drive input words, with random idle bursts until the quiet tail
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.point_x <= '0; in_ch.point_y <= '0;
      in_ch.start_x <= '0; in_ch.start_y <= '0;
      in_ch.end_x   <= '0; in_ch.end_y   <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      quiet = (pending_q.size() < 150);
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        query_t q;
        q = pending_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= q.px; in_ch.point_y <= q.py;
        in_ch.start_x <= q.ax; in_ch.start_y <= q.ay;
        in_ch.end_x   <= q.bx; in_ch.end_y   <= q.by;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side in random bursts
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Predict each accepted word; check each delivered result
  int idle_cycles = 0;
  always @(posedge clk) begin
    query_t  q;
    answer_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        q = {in_ch.point_x, in_ch.point_y, in_ch.start_x, in_ch.start_y,
             in_ch.end_x, in_ch.end_y};
        answer_q.push_back(seg_distance(q));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: distance %0d nearest_case %0d",
                 out_ch.distance, out_ch.nearest_case);
          fails++;
        end else begin
          want = answer_q.pop_front();
          checked++;
          if (want.nearest_case <= CASE_FOOT) case_hits[want.nearest_case]++;
          if (out_ch.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_ch.distance);
            fails++;
          end
          if (out_ch.nearest_case !== want.nearest_case) begin
            $error("nearest_case: expected %0d, got %0d",
                   want.nearest_case, out_ch.nearest_case);
            fails++;
          end
        end
      end
      // Watchdog on cycles with no handshake on either side
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
        $display("timeout with %0d results outstanding", answer_q.size());
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
